/* src/mta_pkg.sv */
// Package for the max triangle area block: item types, widths, sequencer states.
`timescale 1ns / 1ps
`default_nettype none

package mta_pkg;

  // Field widths
  localparam int COORD_BITS = 12;
  localparam int AREA_BITS  = 25;
  // Coordinate differences, products and the running maximum
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int BEST_BITS  = PROD_BITS;
  // Smallest set that holds a triangle
  localparam int MIN_POINTS = 3;

  // One input item
  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic                         set_end;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [AREA_BITS-1:0] double_area;
    logic                 overflowed;
  } out_item_t;

  // One stored point
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  // Triple walk sequencer
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_LD_A,
    ST_LD_AW,
    ST_LD_B,
    ST_LD_BW,
    ST_RD_C,
    ST_DIFF,
    ST_MUL_A,
    ST_MUL_B,
    ST_CMP,
    ST_DONE
  } state_e;

  // Datapath controls from sequencer to the cross product unit
  typedef struct packed {
    logic cap_a;
    logic cap_b;
    logic diff;
    logic mul_a;
    logic mul_b;
    logic cmp;
    logic clr_best;
  } ctrl_t;

endpackage

`default_nettype wire

/* src/mta_point_mem.sv */
// Point store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mta_point_mem #(
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire mta_pkg::point_t          wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output mta_pkg::point_t               rdata_o
);

  mta_pkg::point_t mem_q [DEPTH];
  mta_pkg::point_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/mta_cross_unit.sv */
// Cross product unit: point registers, one shared multiplier, abs and running max.
`timescale 1ns / 1ps
`default_nettype none

module mta_cross_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mta_pkg::ctrl_t              ctrl_i,
  input  wire mta_pkg::point_t             rdata_i,
  output logic [mta_pkg::BEST_BITS-1:0]    best_o
);

  localparam int CB = mta_pkg::COORD_BITS;
  localparam int DB = mta_pkg::DIFF_BITS;
  localparam int PB = mta_pkg::PROD_BITS;
  localparam int XB = mta_pkg::CROSS_BITS;
  localparam int BB = mta_pkg::BEST_BITS;

  mta_pkg::point_t        a_q;
  logic signed [DB-1:0]   ux_q, uy_q, vx_q, vy_q;
  logic signed [DB-1:0]   dx, dy;
  logic signed [DB-1:0]   op_a, op_b;
  logic signed [PB-1:0]   prod;
  logic signed [PB-1:0]   p1_q, p2_q;
  logic signed [XB-1:0]   cross_sum;
  logic        [XB-1:0]   mag;
  logic        [BB-1:0]   best_q;

  // difference of the read point to the anchor point
  assign dx = {rdata_i.x[CB-1], rdata_i.x} - {a_q.x[CB-1], a_q.x};
  assign dy = {rdata_i.y[CB-1], rdata_i.y} - {a_q.y[CB-1], a_q.y};

  // shared multiplier: ux*vy first, then vx*uy
  assign op_a = ctrl_i.mul_a ? ux_q : vx_q;
  assign op_b = ctrl_i.mul_a ? vy_q : uy_q;
  assign prod = op_a * op_b;

  // absolute cross product
  assign cross_sum = {p1_q[PB-1], p1_q} - {p2_q[PB-1], p2_q};
  assign mag       = cross_sum[XB-1] ? XB'(-cross_sum) : XB'(cross_sum);

  // operand and product registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_a) begin
      a_q <= rdata_i;
    end
    if (ctrl_i.cap_b) begin
      ux_q <= dx;
      uy_q <= dy;
    end
    if (ctrl_i.diff) begin
      vx_q <= dx;
      vy_q <= dy;
    end
    if (ctrl_i.mul_a) begin
      p1_q <= prod;
    end
    if (ctrl_i.mul_b) begin
      p2_q <= prod;
    end
  end

  // running maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else if (ctrl_i.clr_best) begin
      best_q <= '0;
    end else if (ctrl_i.cmp && (mag[BB-1:0] > best_q)) begin
      best_q <= mag[BB-1:0];
    end
  end

  assign best_o = best_q;

endmodule

`default_nettype wire

/* src/mta_seq.sv */
// Sequencer: point loading, triple index walk, result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module mta_seq #(
  parameter int MAX_POINTS = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          set_end_i,
  output logic                               in_stall_o,
  input  wire logic                          out_free_i,
  output logic                               emit_o,
  output logic                               drop_o,
  output logic                               mem_we_o,
  output logic [$clog2(MAX_POINTS)-1:0]      mem_waddr_o,
  output logic                               mem_re_o,
  output logic [$clog2(MAX_POINTS)-1:0]      mem_raddr_o,
  output mta_pkg::ctrl_t                     ctrl_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  mta_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d, count_inc;
  logic             drop_q, drop_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IDX_W-1:0] last;
  logic             accept, has_room;

  assign accept    = in_valid_i && (state_q == mta_pkg::ST_LOAD);
  assign has_room  = count_q < CNT_W'(MAX_POINTS);
  assign count_inc = count_q + CNT_W'(has_room);
  assign last      = IDX_W'(count_q - CNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mta_pkg::ST_LOAD: begin
        if (accept && set_end_i) begin
          state_d = (count_inc >= CNT_W'(mta_pkg::MIN_POINTS)) ? mta_pkg::ST_LD_A
                                                               : mta_pkg::ST_DONE;
        end
      end
      mta_pkg::ST_LD_A:  state_d = mta_pkg::ST_LD_AW;
      mta_pkg::ST_LD_AW: state_d = mta_pkg::ST_LD_B;
      mta_pkg::ST_LD_B:  state_d = mta_pkg::ST_LD_BW;
      mta_pkg::ST_LD_BW: state_d = mta_pkg::ST_RD_C;
      mta_pkg::ST_RD_C:  state_d = mta_pkg::ST_DIFF;
      mta_pkg::ST_DIFF:  state_d = mta_pkg::ST_MUL_A;
      mta_pkg::ST_MUL_A: state_d = mta_pkg::ST_MUL_B;
      mta_pkg::ST_MUL_B: state_d = mta_pkg::ST_CMP;
      mta_pkg::ST_CMP: begin
        if (k_q != last) begin
          state_d = mta_pkg::ST_RD_C;
        end else if (j_q != last - IDX_W'(1)) begin
          state_d = mta_pkg::ST_LD_B;
        end else if (i_q != last - IDX_W'(2)) begin
          state_d = mta_pkg::ST_LD_A;
        end else begin
          state_d = mta_pkg::ST_DONE;
        end
      end
      mta_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = mta_pkg::ST_LOAD;
        end
      end
      default: state_d = mta_pkg::ST_LOAD;
    endcase
  end

  // outputs: handshake, memory port and datapath controls
  always_comb begin
    ctrl_o      = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = k_q;
    emit_o      = 1'b0;
    in_stall_o  = (state_q != mta_pkg::ST_LOAD);
    mem_we_o    = accept && has_room;
    mem_waddr_o = count_q[IDX_W-1:0];
    case (state_q)
      mta_pkg::ST_LD_A: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = i_q;
      end
      mta_pkg::ST_LD_AW: ctrl_o.cap_a = 1'b1;
      mta_pkg::ST_LD_B: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = j_q;
      end
      mta_pkg::ST_LD_BW: ctrl_o.cap_b = 1'b1;
      mta_pkg::ST_RD_C: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = k_q;
      end
      mta_pkg::ST_DIFF:  ctrl_o.diff  = 1'b1;
      mta_pkg::ST_MUL_A: ctrl_o.mul_a = 1'b1;
      mta_pkg::ST_MUL_B: ctrl_o.mul_b = 1'b1;
      mta_pkg::ST_CMP:   ctrl_o.cmp   = 1'b1;
      mta_pkg::ST_DONE: begin
        emit_o          = out_free_i;
        ctrl_o.clr_best = out_free_i;
      end
      default: ;
    endcase
  end

  // point count, drop flag and triple indices
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    if (accept) begin
      count_d = count_inc;
      drop_d  = drop_q | !has_room;
      i_d     = '0;
    end
    case (state_q)
      mta_pkg::ST_LD_A: j_d = i_q + IDX_W'(1);
      mta_pkg::ST_LD_B: k_d = j_q + IDX_W'(1);
      mta_pkg::ST_CMP: begin
        if (k_q != last) begin
          k_d = k_q + IDX_W'(1);
        end else if (j_q != last - IDX_W'(1)) begin
          j_d = j_q + IDX_W'(1);
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      mta_pkg::ST_DONE: begin
        if (out_free_i) begin
          count_d = '0;
          drop_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mta_pkg::ST_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign drop_o = drop_q;

endmodule

`default_nettype wire

/* src/max_triangle_area_top.sv */
// Top level of the max triangle area block: store, sequencer, cross unit, result register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_item_i  (px, py, set_end)
//   out      output     out_valid_o/out_stall_i out_item_o (double_area, overflowed)
//
// Points load at one per cycle. An item with set_end starts the triple walk,
// during which in_stall_o is high. Triples are walked one after another, the first and
// second points read anew from the store as they change, set by the single multiplier
// and the single read port of the point store. Sets of fewer than three points skip
// the walk and go straight to the result hand-off.
// Reset needs no clearing pass; loading of the next set runs while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module max_triangle_area_top #(
  parameter int MAX_POINTS = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire mta_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output mta_pkg::out_item_t       out_item_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int AB    = mta_pkg::AREA_BITS;
  localparam int BB    = mta_pkg::BEST_BITS;

  logic                  mem_we, mem_re, emit, drop, out_free;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  mta_pkg::point_t       wdata, rdata;
  mta_pkg::ctrl_t        ctrl;
  logic [BB-1:0]         best;
  logic                  out_valid_q, out_valid_d;
  mta_pkg::out_item_t    out_q;

  assign wdata.x  = in_item_i.px;
  assign wdata.y  = in_item_i.py;
  assign out_free = !out_valid_q || !out_stall_i;

  mta_point_mem #(
    .DEPTH (MAX_POINTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  mta_seq #(
    .MAX_POINTS (MAX_POINTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .set_end_i   (in_item_i.set_end),
    .in_stall_o  (in_stall_o),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .drop_o      (drop),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .ctrl_o      (ctrl)
  );

  mta_cross_unit u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .rdata_i (rdata),
    .best_o  (best)
  );

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, saturated to the area width
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.double_area <= (|best[BB-1:AB]) ? {AB{1'b1}} : best[AB-1:0];
      out_q.overflowed  <= drop;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // a new result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || !out_stall_i))
    else $error("result emitted while output register busy");

  // the item closing a set starts the walk or the hand-off
  a_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.set_end) |=> in_stall_o)
    else $error("input not stalled after end of set");

  // store writes only happen on accepted items
  a_we_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (in_valid_i && !in_stall_o))
    else $error("point store written without an accepted item");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for max_triangle_area_top: point sets checked against a behavioral area model.
`timescale 1ns / 1ps

module tb;

  localparam int CW          = mta_pkg::COORD_BITS;
  localparam int AW          = mta_pkg::AREA_BITS;
  localparam int MAX_PTS     = 128;
  localparam int AREA_CAP    = (1 << AW) - 1;
  localparam int STALL_LIMIT = 10_000_000;  // watchdog limit, well above the length of a full store walk
  localparam int RAND_ITEMS  = 240;
  localparam int N_DIR       = 17;

  // One row of the directed table; typed rows carry a hand-written result
  typedef struct {
    int x;
    int y;
    bit last;
    bit typed;
    int area;
    bit ovf;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  mta_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  mta_pkg::out_item_t out_item_o;

  max_triangle_area_top #(
    .MAX_POINTS(MAX_PTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Model of the point store and the open set
  longint             pt_x[MAX_PTS];
  longint             pt_y[MAX_PTS];
  int                 pt_count;
  bit                 pt_dropped;
  mta_pkg::out_item_t area_q[$];     // results still owed by the block, oldest first

  int                 n_errors;
  int                 idle_cycles;
  int                 items_sent;
  int                 tx_idle_pct;
  int                 rx_stall_pct;
  mta_pkg::out_item_t want;
  dir_row_t           dir_rows[N_DIR];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int wanted);
    n_errors++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
  endtask

  // Close the open set: largest |cross product| over all triples, then clear
  function automatic mta_pkg::out_item_t close_set();
    longint             best;
    longint             cr;
    mta_pkg::out_item_t r;
    best = 0;
    for (int i = 0; i + 2 < pt_count; i++)
      for (int j = i + 1; j + 1 < pt_count; j++)
        for (int k = j + 1; k < pt_count; k++) begin
          cr = (pt_x[j] - pt_x[i]) * (pt_y[k] - pt_y[i])
             - (pt_x[k] - pt_x[i]) * (pt_y[j] - pt_y[i]);
          if (cr < 0) cr = -cr;
          if (cr > best) best = cr;
        end
    if (best > AREA_CAP) best = AREA_CAP;
    r.double_area = best[AW-1:0];
    r.overflowed  = pt_dropped;
    pt_count   = 0;
    pt_dropped = 1'b0;
    return r;
  endfunction

  // Drive one point; called and returns at a falling edge
  task automatic send_point(input int x, input int y, input bit last,
                            input bit typed, input int area, input bit ovf);
    mta_pkg::in_item_t  it;
    mta_pkg::out_item_t res;
    it.px      = x[CW-1:0];
    it.py      = y[CW-1:0];
    it.set_end = last;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    // item accepted: update the store model
    if (pt_count < MAX_PTS) begin
      pt_x[pt_count] = longint'($signed(it.px));
      pt_y[pt_count] = longint'($signed(it.py));
      pt_count++;
    end else begin
      pt_dropped = 1'b1;
    end
    if (last) begin
      res = close_set();
      if (typed) begin
        res.double_area = area[AW-1:0];
        res.overflowed  = ovf;
      end
      area_q.push_back(res);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // Random coordinate: narrow span for collinear and repeated points, corners, or full range
  function automatic int pick_coord(input int mode);
    logic [CW-1:0] bits;
    bits = CW'($urandom);
    case (mode)
      0, 1:    return int'($urandom_range(6)) - 3;
      2:       return $urandom_range(1) ? 2047 : -2048;
      default: return $signed(bits);
    endcase
  endfunction

  task automatic send_set(input int n_pts);
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < n_pts; i++)
      send_point(pick_coord(mode), pick_coord(mode), i == n_pts - 1, 1'b0, 0, 1'b0);
  endtask

  // Receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // Result checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else if (out_valid_o && !out_stall_i) begin
        if (area_q.size() == 0) begin
          report_mismatch("unexpected result", out_item_o.double_area, 0);
        end else begin
          want = area_q.pop_front();
          if (out_item_o.double_area !== want.double_area)
            report_mismatch("double_area", out_item_o.double_area, want.double_area);
          if (out_item_o.overflowed !== want.overflowed)
            report_mismatch("overflowed", out_item_o.overflowed, want.overflowed);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int goal;
    int pick;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_stall_i  = 1'b0;
    n_errors     = 0;
    idle_cycles  = 0;
    items_sent   = 0;
    pt_count     = 0;
    pt_dropped   = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    dir_rows = '{
      // lone point closes a set
      '{0, 0, 1, 1, 0, 0},
      // two points
      '{-2048, 2047, 0, 0, 0, 0},
      '{2047, -2048, 1, 1, 0, 0},
      // largest right triangle at the corners
      '{-2048, -2048, 0, 0, 0, 0},
      '{2047, -2048, 0, 0, 0, 0},
      '{-2048, 2047, 1, 1, 16769025, 0},
      // collinear points
      '{-1, -1, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0},
      '{1, 1, 0, 0, 0, 0},
      '{2047, 2047, 1, 1, 0, 0},
      // repeated point
      '{5, -7, 0, 0, 0, 0},
      '{5, -7, 0, 0, 0, 0},
      '{5, -7, 1, 1, 0, 0},
      // mixed signs, checked by the model
      '{-1, 0, 0, 0, 0, 0},
      '{0, -1, 0, 0, 0, 0},
      '{2047, 2047, 0, 0, 0, 0},
      '{-2048, 0, 1, 0, 0, 0}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r])
      send_point(dir_rows[r].x, dir_rows[r].y, dir_rows[r].last,
                 dir_rows[r].typed, dir_rows[r].area, dir_rows[r].ovf);

    // Random sets in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct  = (ph == 0) ? 22 : (ph == 1) ? 60 : 0;
      rx_stall_pct = (ph == 0) ? 60 : (ph == 1) ? 22 : 0;
      // hold off until every owed result is back
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (area_q.size() != 0);
      // overfull set: the last two points are dropped, the last while it closes the set
      if (ph == 2) send_set(MAX_PTS + 2);
      goal = items_sent + RAND_ITEMS / 3;
      while (items_sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 12)      send_set($urandom_range(1, 2));
        else if (pick < 92) send_set($urandom_range(3, 10));
        else                send_set($urandom_range(11, 22));
      end
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (area_q.size() != 0);
    repeat (50) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mta_pkg.sv
src/mta_point_mem.sv
src/mta_cross_unit.sv
src/mta_seq.sv
src/max_triangle_area_top.sv
tb/tb.sv
